[sv/ttb_pkg.sv]
package ttb_pkg;

    // Default screen geometry and backing store size
    localparam int COLUMNS_DEF     = 80;
    localparam int ROWS_DEF        = 50;
    localparam int STORE_DEPTH_DEF = 4096;

    // Fixed field widths of the channels
    localparam int CHAR_W   = 8;
    localparam int CIDX_W   = 12;
    localparam int CURPOS_W = 12;

    // Command and key codes
    localparam logic              CMD_KEY       = 1'b0;
    localparam logic              CMD_READ      = 1'b1;
    localparam logic [CHAR_W-1:0] KEY_NEWLINE   = 8'd13;
    localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'd8;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_CHAR,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_READ
    } t_op;

    typedef struct packed {
        logic              command;
        logic [CHAR_W-1:0] char_code;
        logic [CIDX_W-1:0] cell_index;
    } t_in_beat;

    typedef struct packed {
        logic [CHAR_W-1:0]   read_data;
        logic [CURPOS_W-1:0] cursor_position;
        logic                scrolled;
    } t_out_beat;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] char_code;
        logic [CIDX_W-1:0] cell_index;
    } t_cmd;

endpackage

[sv/ttb_front.sv]
// Input stage: take a beat, decode it into an operation, hand it to the queue.
module ttb_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_hold,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ttb_pkg::t_in_beat i_in_beat,
    output logic            o_push_valid,
    output ttb_pkg::t_cmd   o_push_cmd,
    input  logic            i_push_ready
);

    logic          r_valid;
    ttb_pkg::t_cmd r_cmd;
    ttb_pkg::t_cmd n_cmd;
    logic          accept;
    logic          push;

    assign push       = r_valid && i_push_ready;
    assign o_in_stall = i_hold || (r_valid && !i_push_ready);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_cmd.char_code  = i_in_beat.char_code;
        n_cmd.cell_index = i_in_beat.cell_index;
        if (i_in_beat.command == ttb_pkg::CMD_READ) begin
            n_cmd.op = ttb_pkg::OP_READ;
        end else if (i_in_beat.char_code == ttb_pkg::KEY_NEWLINE) begin
            n_cmd.op = ttb_pkg::OP_NEWLINE;
        end else if (i_in_beat.char_code == ttb_pkg::KEY_BACKSPACE) begin
            n_cmd.op = ttb_pkg::OP_BACKSPACE;
        end else begin
            n_cmd.op = ttb_pkg::OP_CHAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

endmodule

[sv/ttb_queue.sv]
// Small FIFO between decode and execution.
module ttb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  ttb_pkg::t_cmd i_push_cmd,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output ttb_pkg::t_cmd o_pop_cmd,
    input  logic          i_pop_ready
);

    localparam int PW = (ttb_pkg::QUEUE_DEPTH > 1) ? $clog2(ttb_pkg::QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(ttb_pkg::QUEUE_DEPTH + 1);

    ttb_pkg::t_cmd r_slot [ttb_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;
    logic          push;
    logic          pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        if (p == PW'(ttb_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_push_ready = (r_count != NW'(ttb_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_cmd    = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

[sv/ttb_back.sv]
// Execution: cursor tracking, screen store, scroll and clear sequencer, result register.
module ttb_back #(
    parameter int COLUMNS     = ttb_pkg::COLUMNS_DEF,
    parameter int ROWS        = ttb_pkg::ROWS_DEF,
    parameter int STORE_DEPTH = ttb_pkg::STORE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pop_valid,
    input  ttb_pkg::t_cmd      i_pop_cmd,
    output logic               o_pop_ready,
    output logic               o_clearing,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ttb_pkg::t_out_beat o_out_beat
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(CELLS + 1);
    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int LW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int XW0   = (CW > AW) ? CW : AW;
    localparam int XW    = (XW0 > ttb_pkg::CIDX_W) ? XW0 : ttb_pkg::CIDX_W;

    localparam logic [XW-1:0] SCROLL_X = XW'(CELLS - COLUMNS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_SCR_CLR
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_cursor;
    logic [LW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    logic [XW-1:0]      r_idx;
    logic               r_rd_zero;
    logic [7:0]         r_rd_data;
    logic               r_out_valid;
    ttb_pkg::t_out_beat r_out_beat;

    logic [7:0] r_mem [STORE_DEPTH];

    logic               pop;
    logic               mem_we;
    logic [XW-1:0]      mem_waddr;
    logic [7:0]         mem_wdata;
    logic               mem_re;
    logic [XW-1:0]      mem_raddr;
    logic [CW-1:0]      n_cursor;
    logic [LW-1:0]      n_col;
    logic [RW-1:0]      n_row;
    logic               scroll_hit;
    logic [XW-1:0]      cur_x;
    logic [XW-1:0]      ncur_x;
    logic [XW-1:0]      idx_x;

    function automatic logic in_store(input logic [XW-1:0] a);
        return ({1'b0, a} < (XW + 1)'(STORE_DEPTH));
    endfunction

    assign o_pop_ready = (r_state == ST_IDLE) && !r_out_valid;
    assign pop         = o_pop_ready && i_pop_valid;
    assign o_clearing  = (r_state == ST_CLEAR);
    assign cur_x       = XW'(r_cursor);
    assign ncur_x      = XW'(n_cursor);
    assign idx_x       = XW'(i_pop_cmd.cell_index);

    // Next cursor for a key item, and memory port controls for every state
    always_comb begin
        n_cursor   = r_cursor;
        n_col      = r_col;
        n_row      = r_row;
        scroll_hit = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = idx_x;
        case (i_pop_cmd.op)
            ttb_pkg::OP_CHAR: begin
                n_cursor = r_cursor + 1'b1;
                if (r_col == LW'(COLUMNS - 1)) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
                scroll_hit = (r_cursor == CW'(CELLS - 1));
            end
            ttb_pkg::OP_NEWLINE: begin
                n_cursor   = r_cursor - CW'(r_col) + CW'(COLUMNS);
                n_col      = '0;
                n_row      = r_row + 1'b1;
                scroll_hit = (r_row == RW'(ROWS - 1));
            end
            ttb_pkg::OP_BACKSPACE: begin
                if (r_cursor != '0) begin
                    n_cursor = r_cursor - 1'b1;
                    if (r_col == '0) begin
                        n_col = LW'(COLUMNS - 1);
                        n_row = r_row - 1'b1;
                    end else begin
                        n_col = r_col - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                if (pop) begin
                    case (i_pop_cmd.op)
                        ttb_pkg::OP_CHAR: begin
                            mem_we    = in_store(cur_x);
                            mem_waddr = cur_x;
                            mem_wdata = i_pop_cmd.char_code;
                        end
                        ttb_pkg::OP_BACKSPACE: begin
                            mem_we    = (r_cursor != '0) && in_store(ncur_x);
                            mem_waddr = ncur_x;
                        end
                        ttb_pkg::OP_READ: begin
                            mem_re = in_store(idx_x);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCR_RD: begin
                mem_raddr = r_idx + XW'(COLUMNS);
                mem_re    = in_store(mem_raddr);
            end
            ST_SCR_WR: begin
                mem_we    = in_store(r_idx);
                mem_wdata = r_rd_zero ? 8'd0 : r_rd_data;
            end
            ST_SCR_CLR: begin
                mem_we = in_store(r_idx);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr[AW-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cursor    <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == XW'(STORE_DEPTH - 1)) begin
                        r_idx   <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (pop) begin
                        if (i_pop_cmd.op == ttb_pkg::OP_READ) begin
                            r_rd_zero <= !in_store(idx_x);
                            r_state   <= ST_READ;
                        end else if (scroll_hit) begin
                            r_cursor <= CW'(CELLS - COLUMNS);
                            r_col    <= '0;
                            r_row    <= RW'(ROWS - 1);
                            r_idx    <= '0;
                            r_state  <= ST_SCR_RD;
                        end else begin
                            r_cursor                   <= n_cursor;
                            r_col                      <= n_col;
                            r_row                      <= n_row;
                            r_out_valid                <= 1'b1;
                            r_out_beat.read_data       <= '0;
                            r_out_beat.cursor_position <= ncur_x[ttb_pkg::CURPOS_W-1:0];
                            r_out_beat.scrolled        <= 1'b0;
                        end
                    end
                end
                ST_READ: begin
                    r_out_valid                <= 1'b1;
                    r_out_beat.read_data       <= r_rd_zero ? 8'd0 : r_rd_data;
                    r_out_beat.cursor_position <= cur_x[ttb_pkg::CURPOS_W-1:0];
                    r_out_beat.scrolled        <= 1'b0;
                    r_state                    <= ST_IDLE;
                end
                ST_SCR_RD: begin
                    r_rd_zero <= !mem_re;
                    r_state   <= ST_SCR_WR;
                end
                ST_SCR_WR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == XW'(CELLS - COLUMNS - 1)) begin
                        r_state <= ST_SCR_CLR;
                    end else begin
                        r_state <= ST_SCR_RD;
                    end
                end
                ST_SCR_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == XW'(CELLS - 1)) begin
                        r_out_valid                <= 1'b1;
                        r_out_beat.read_data       <= '0;
                        r_out_beat.cursor_position <= SCROLL_X[ttb_pkg::CURPOS_W-1:0];
                        r_out_beat.scrolled        <= 1'b1;
                        r_state                    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor < CW'(CELLS))
        else $error("cursor left the screen");

    a_cursor_rowcol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor == CW'(int'(r_row) * COLUMNS + int'(r_col)))
        else $error("cursor out of step with row and column");

    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.scrolled |->
            o_out_beat.cursor_position == SCROLL_X[ttb_pkg::CURPOS_W-1:0]
            && o_out_beat.read_data == '0)
        else $error("scroll result without last-row cursor");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clearing |-> !o_out_valid && !pop)
        else $error("activity during reset clear");

endmodule

[sv/text_terminal_buffer.sv]
// Channel | Direction | Handshake                | Beat
// in      | input     | i_in_valid / o_in_stall   | command, char_code, cell_index
// out     | output    | o_out_valid / i_out_stall | read_data, cursor_position, scrolled
//
// A key beat passes the front register, the queue and the result register; a read
// also passes ST_READ. The executor takes a new beat only once its result register
// is empty. A scroll copies each cell up a row through a read and a write state,
// then clears the last row one cell a cycle. After reset the whole store
// (STORE_DEPTH, 4096 by default) is swept to zero with o_in_stall high;
// a stalled output holds its beat while the queue fills.
module text_terminal_buffer #(
    parameter int COLUMNS     = ttb_pkg::COLUMNS_DEF,
    parameter int ROWS        = ttb_pkg::ROWS_DEF,
    parameter int STORE_DEPTH = ttb_pkg::STORE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ttb_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ttb_pkg::t_out_beat o_out_beat
);

    // Front to queue
    logic          push_valid;
    logic          push_ready;
    ttb_pkg::t_cmd push_cmd;

    // Queue to back
    logic          pop_valid;
    logic          pop_ready;
    ttb_pkg::t_cmd pop_cmd;

    // High while the store is being swept after reset
    logic          clearing;

    // Decode each beat into an operation
    ttb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hold       (clearing),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_beat    (i_in_beat),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready)
    );

    // Decouple decode from execution so each side stalls on its own
    ttb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop_ready  (pop_ready)
    );

    // Move the cursor, write or read the store, scroll, hold the result
    ttb_back #(
        .COLUMNS     (COLUMNS),
        .ROWS        (ROWS),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_cmd   (pop_cmd),
        .o_pop_ready (pop_ready),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule

[sim/tb_text_terminal_buffer.sv]
module tb_text_terminal_buffer;

    localparam int COLUMNS     = ttb_pkg::COLUMNS_DEF;
    localparam int ROWS        = ttb_pkg::ROWS_DEF;
    localparam int STORE_DEPTH = ttb_pkg::STORE_DEPTH_DEF;
    localparam int CELLS       = COLUMNS * ROWS;

    // Random beats per idling phase (three phases, about 1350 in all)
    localparam int PHASE_BEATS = 450;

    // The slowest legal run: each scroll copies the screen up a row and clears
    // the last row, and the run also holds the clearing sweep after reset and
    // the stall gaps; the limit allows a wide margin over that.
    localparam int CYCLE_LIMIT = 4_000_000;

    // One stimulus row: the input beat and, where it is obvious, the result
    // typed in by hand. Rows with typed_want low are checked against the
    // screen predictor instead.
    typedef struct packed {
        ttb_pkg::t_in_beat  beat;
        bit                 typed_want;
        ttb_pkg::t_out_beat want;
    } t_key_row;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    ttb_pkg::t_in_beat  in_beat   = '0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    ttb_pkg::t_out_beat out_beat;

    // Predictor state: a mirror of the screen store and the cursor
    logic [ttb_pkg::CHAR_W-1:0] screen_mirror [STORE_DEPTH];
    int unsigned                cursor_mirror;

    t_key_row           key_feed[$];          // rows waiting to be offered to the block
    ttb_pkg::t_out_beat screen_beats_due[$];  // predicted results, oldest first
    t_key_row           row_on_bus;
    ttb_pkg::t_out_beat predicted_beat;
    ttb_pkg::t_out_beat due_beat;

    int unsigned send_idle_pct = 18;
    int unsigned recv_stall_pct = 52;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned beats_taken = 0;
    int unsigned reads_taken = 0;
    int unsigned beats_checked = 0;
    int unsigned scrolls_seen = 0;

    // Directed rows: empty store after reset, backspace at the origin,
    // extreme byte values, ignored fields on both commands, backspace
    // clearing a cell, newline from the row start and from mid-row, and
    // reads past the screen and at the top of the store.
    t_key_row directed_tbl [25] = '{
        '{'{ttb_pkg::CMD_READ, 8'h00, 12'd0},     1'b1, '{8'h00, 12'd0,   1'b0}},
        '{'{ttb_pkg::CMD_READ, 8'hFF, 12'd4095},  1'b1, '{8'h00, 12'd0,   1'b0}},
        '{'{ttb_pkg::CMD_KEY,  ttb_pkg::KEY_BACKSPACE, 12'd0}, 1'b1, '{8'h00, 12'd0, 1'b0}},
        '{'{ttb_pkg::CMD_KEY,  8'h41, 12'hFFF},   1'b1, '{8'h00, 12'd1,   1'b0}},
        '{'{ttb_pkg::CMD_KEY,  8'hFF, 12'd0},     1'b1, '{8'h00, 12'd2,   1'b0}},
        '{'{ttb_pkg::CMD_KEY,  8'h00, 12'hAAA},   1'b1, '{8'h00, 12'd3,   1'b0}},
        '{'{ttb_pkg::CMD_KEY,  8'h55, 12'h555},   1'b1, '{8'h00, 12'd4,   1'b0}},
        '{'{ttb_pkg::CMD_READ, 8'hFF, 12'd0},     1'b1, '{8'h41, 12'd4,   1'b0}},
        '{'{ttb_pkg::CMD_READ, ttb_pkg::KEY_NEWLINE, 12'd1}, 1'b1, '{8'hFF, 12'd4, 1'b0}},
        '{'{ttb_pkg::CMD_READ, ttb_pkg::KEY_BACKSPACE, 12'd3}, 1'b1, '{8'h55, 12'd4, 1'b0}},
        '{'{ttb_pkg::CMD_KEY,  ttb_pkg::KEY_BACKSPACE, 12'd0}, 1'b1, '{8'h00, 12'd3, 1'b0}},
        '{'{ttb_pkg::CMD_READ, 8'h00, 12'd3},     1'b1, '{8'h00, 12'd3,   1'b0}},
        '{'{ttb_pkg::CMD_KEY,  ttb_pkg::KEY_NEWLINE, 12'hFFF}, 1'b1, '{8'h00, 12'd80, 1'b0}},
        '{'{ttb_pkg::CMD_KEY,  8'h0C, 12'd0},     1'b0, '0},
        '{'{ttb_pkg::CMD_KEY,  8'h0E, 12'd0},     1'b0, '0},
        '{'{ttb_pkg::CMD_KEY,  8'h09, 12'd0},     1'b0, '0},
        '{'{ttb_pkg::CMD_KEY,  8'h07, 12'd0},     1'b0, '0},
        '{'{ttb_pkg::CMD_KEY,  ttb_pkg::KEY_NEWLINE, 12'd0}, 1'b1, '{8'h00, 12'd160, 1'b0}},
        '{'{ttb_pkg::CMD_KEY,  ttb_pkg::KEY_BACKSPACE, 12'd0}, 1'b1, '{8'h00, 12'd159, 1'b0}},
        '{'{ttb_pkg::CMD_READ, 8'h00, 12'd81},    1'b0, '0},
        '{'{ttb_pkg::CMD_READ, 8'h00, 12'd3999},  1'b1, '{8'h00, 12'd159, 1'b0}},
        '{'{ttb_pkg::CMD_READ, 8'h00, 12'd4000},  1'b1, '{8'h00, 12'd159, 1'b0}},
        '{'{ttb_pkg::CMD_READ, 8'h00, 12'd4095},  1'b1, '{8'h00, 12'd159, 1'b0}},
        '{'{ttb_pkg::CMD_KEY,  8'h80, 12'd0},     1'b0, '0},
        '{'{ttb_pkg::CMD_KEY,  ttb_pkg::KEY_NEWLINE, 12'd0}, 1'b0, '0}
    };

    text_terminal_buffer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Apply one accepted beat to the mirror and return the result it causes.
    function automatic ttb_pkg::t_out_beat screen_step(ttb_pkg::t_in_beat b);
        ttb_pkg::t_out_beat r;
        int unsigned        pos;
        r = '0;
        if (b.command == ttb_pkg::CMD_READ) begin
            // Addresses past the store read as zero
            if (b.cell_index < STORE_DEPTH) begin
                r.read_data = screen_mirror[b.cell_index];
            end
        end else begin
            if (b.char_code == ttb_pkg::KEY_NEWLINE) begin
                cursor_mirror = (cursor_mirror / COLUMNS + 1) * COLUMNS;
            end else if (b.char_code == ttb_pkg::KEY_BACKSPACE) begin
                // Hold the cursor at the origin
                if (cursor_mirror > 0) begin
                    cursor_mirror--;
                    screen_mirror[cursor_mirror] = '0;
                end
            end else begin
                screen_mirror[cursor_mirror] = b.char_code;
                cursor_mirror++;
            end
            // Scroll within the same beat that runs the cursor off the screen
            if (cursor_mirror >= CELLS) begin
                for (pos = 0; pos + COLUMNS < CELLS; pos++) begin
                    screen_mirror[pos] = screen_mirror[pos + COLUMNS];
                end
                for (pos = CELLS - COLUMNS; pos < CELLS; pos++) begin
                    screen_mirror[pos] = '0;
                end
                cursor_mirror = CELLS - COLUMNS;
                r.scrolled = 1'b1;
            end
        end
        r.cursor_position = cursor_mirror[ttb_pkg::CURPOS_W-1:0];
        return r;
    endfunction

    // Draw one random beat. Reads lean toward cells near the cursor so that
    // freshly typed and freshly scrolled text gets read back.
    function automatic ttb_pkg::t_in_beat random_key_beat();
        ttb_pkg::t_in_beat b;
        ttb_pkg::t_op      op;
        int unsigned       pick;
        int unsigned       span;
        b.command    = ttb_pkg::CMD_KEY;
        b.char_code  = 8'($urandom_range(255));
        b.cell_index = 12'($urandom_range(4095));
        pick = $urandom_range(99);
        if (pick < 30) begin
            op = ttb_pkg::OP_READ;
        end else if (pick < 82) begin
            op = ttb_pkg::OP_CHAR;
        end else if (pick < 94) begin
            op = ttb_pkg::OP_BACKSPACE;
        end else begin
            op = ttb_pkg::OP_NEWLINE;
        end
        case (op)
            ttb_pkg::OP_READ: begin
                b.command = ttb_pkg::CMD_READ;
                pick = $urandom_range(9);
                if (pick < 5) begin
                    span = (cursor_mirror < 240) ? cursor_mirror : 240;
                    b.cell_index = 12'(cursor_mirror - $urandom_range(span));
                end else if (pick < 9) begin
                    b.cell_index = 12'($urandom_range(CELLS - 1));
                end else begin
                    b.cell_index = 12'($urandom_range(4095, CELLS));
                end
            end
            ttb_pkg::OP_CHAR: begin
                while (b.char_code == ttb_pkg::KEY_NEWLINE
                       || b.char_code == ttb_pkg::KEY_BACKSPACE) begin
                    b.char_code = 8'($urandom_range(255));
                end
            end
            ttb_pkg::OP_BACKSPACE: b.char_code = ttb_pkg::KEY_BACKSPACE;
            default:               b.char_code = ttb_pkg::KEY_NEWLINE;
        endcase
        return b;
    endfunction

    // Sender: on acceptance advance the predictor, then offer the next row
    // or drop valid and idle. A stalled beat is held unchanged.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predicted_beat = screen_step(row_on_bus.beat);
                screen_beats_due.push_back(row_on_bus.typed_want ? row_on_bus.want
                                                                 : predicted_beat);
                beats_taken++;
                if (row_on_bus.beat.command == ttb_pkg::CMD_READ) begin
                    reads_taken++;
                end
            end
            if (!in_valid || !in_stall) begin
                if (key_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    row_on_bus = key_feed.pop_front();
                    in_beat  <= row_on_bus.beat;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted beat against the oldest prediction,
    // then pick the stall for the next cycle.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                beats_checked++;
                if (out_beat.scrolled === 1'b1) begin
                    scrolls_seen++;
                end
                if (screen_beats_due.size() == 0) begin
                    $error("result beat with nothing due: %p", out_beat);
                    fail_count++;
                end else begin
                    due_beat = screen_beats_due.pop_front();
                    if (out_beat.read_data !== due_beat.read_data) begin
                        $error("read_data: expected %0d, got %0d",
                               due_beat.read_data, out_beat.read_data);
                        fail_count++;
                    end
                    if (out_beat.cursor_position !== due_beat.cursor_position) begin
                        $error("cursor_position: expected %0d, got %0d",
                               due_beat.cursor_position, out_beat.cursor_position);
                        fail_count++;
                    end
                    if (out_beat.scrolled !== due_beat.scrolled) begin
                        $error("scrolled: expected %0d, got %0d",
                               due_beat.scrolled, out_beat.scrolled);
                        fail_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_text_terminal_buffer NOT OK");
        $finish;
    end

    initial begin
        t_key_row row;
        int       phase;
        int       n;
        int       settle;

        for (n = 0; n < STORE_DEPTH; n++) begin
            screen_mirror[n] = '0;
        end
        cursor_mirror = 0;

        // Hold reset, then release it; the block then sweeps its store
        // with the input stalled.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        foreach (directed_tbl[i]) begin
            while (key_feed.size() >= 2) @(negedge clk);
            key_feed.push_back(directed_tbl[i]);
        end

        // Phase 0: sender idles lightly, receiver stalls heavily.
        // Phase 1: the other way round. Phase 2: no idling at all.
        for (phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct  = 52;
                recv_stall_pct = 18;
            end else if (phase == 2) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            for (n = 0; n < PHASE_BEATS; n++) begin
                while (key_feed.size() >= 2) @(negedge clk);
                row            = '0;
                row.beat       = random_key_beat();
                row.typed_want = 1'b0;
                key_feed.push_back(row);
            end
        end

        // Drain: every row accepted, every result back, then a short settle
        while (key_feed.size() != 0 || in_valid) @(negedge clk);
        while (screen_beats_due.size() != 0) @(negedge clk);
        for (settle = 0; settle < 16; settle++) @(negedge clk);
        if (screen_beats_due.size() != 0) begin
            $error("%0d result beats never arrived", screen_beats_due.size());
            fail_count++;
        end

        $display("Sent %0d beats (%0d reads), checked %0d results, %0d scrolls seen.",
                 beats_taken, reads_taken, beats_checked, scrolls_seen);
        $display("Ran %0d cycles across three idling phases; %0d mismatches.",
                 cycle_count, fail_count);
        if (fail_count == 0) begin
            $display("tb_text_terminal_buffer OK");
        end else begin
            $display("tb_text_terminal_buffer NOT OK");
        end
        $finish;
    end

endmodule
